FILE: src/dst_pkg.sv
package dst_pkg;

	localparam int SLOTS = 64;
	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int HANDLE_BITS = 32;
	localparam int CONSOLE_SLOTS = 3;

	localparam logic [2:0] CMD_ASSIGN = 3'd0;
	localparam logic [2:0] CMD_RELEASE = 3'd1;
	localparam logic [2:0] CMD_REASSIGN = 3'd2;
	localparam logic [2:0] CMD_GET = 3'd3;
	localparam logic [2:0] CMD_LIST = 3'd4;

	localparam logic [2:0] KIND_ANY = 3'd1;
	localparam logic [2:0] KIND_FILE = 3'd2;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_DESC = 2'd1,
		ST_INVALID = 2'd2,
		ST_NO_SPACE = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] pad;
		logic [2:0] kind_in;
		logic [31:0] handle_in;
		logic signed [15:0] slot_index;
		logic [2:0] command;
	} in_item_t;

	typedef struct packed {
		logic [3:0] pad;
		logic found;
		logic [2:0] kind_out;
		logic [31:0] handle_out;
		logic [5:0] slot_out;
		status_t status;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic commit;
		logic scan_rd;
		logic scan_step;
		logic scan_done;
	} dst_ctl_t;

	typedef struct packed {
		logic in_list;
		logic out_free;
		logic scan_match;
		logic pend_valid;
		logic cursor_last;
	} dst_stat_t;

endpackage

FILE: src/descriptor_slot_table.sv
// Single-slot commands: the command is registered, then its result goes to the output register once that is free.
// Single-slot commands are taken one at a time; the next item is accepted after the result is committed.
// List: each slot is read and then checked through the one table read port; a held result stalls the scan.
// Reset is asynchronous and active low; occupancy returns to the three console slots.
// Table contents need no clearing pass; the console entries are served from reset flags.
module descriptor_slot_table (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// command[2:0], slot_index[18:3], handle_in[50:19], kind_in[53:51], zero fill.
	input logic [55:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// status[1:0], slot_out[7:2], handle_out[39:8], kind_out[42:40], found[43], zero fill.
	output logic [47:0] m_tdata,
	output logic m_tlast
);

	dst_pkg::dst_ctl_t ctl;
	dst_pkg::dst_stat_t stat;

	dst_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat(stat),
		.ctl(ctl)
	);

	dst_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.stat(stat),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

FILE: src/dst_ctrl.sv
module dst_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input dst_pkg::dst_stat_t stat,
	output dst_pkg::dst_ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SCAN_END
	} state_t;

	state_t state_q;
	state_t state_d;
	logic ready_q;

	assign s_tready = ready_q;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && ready_q) begin
					ctl.load = 1'b1;
					state_d = stat.in_list ? S_SCAN_RD : S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					ctl.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SCAN_RD: begin
				ctl.scan_rd = 1'b1;
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (!(stat.scan_match && stat.pend_valid && !stat.out_free)) begin
					ctl.scan_step = 1'b1;
					state_d = stat.cursor_last ? S_SCAN_END : S_SCAN_RD;
				end
			end
			S_SCAN_END: begin
				if (stat.out_free) begin
					ctl.scan_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
		end
	end

endmodule

FILE: src/dst_datapath.sv
module dst_datapath (
	input logic clk,
	input logic arst_n,
	input dst_pkg::dst_ctl_t ctl,
	output dst_pkg::dst_stat_t stat,
	input logic [55:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	output logic [47:0] m_tdata,
	output logic m_tlast
);

	localparam int ENTRY_BITS = dst_pkg::HANDLE_BITS + 3;

	dst_pkg::in_item_t in_word;

	logic [2:0] cmd_q;
	logic signed [15:0] idx_q;
	logic [dst_pkg::HANDLE_BITS-1:0] hnd_q;
	logic [2:0] kind_q;

	logic [dst_pkg::SLOTS-1:0] occ_q;
	logic [dst_pkg::CONSOLE_SLOTS-1:0] init_q;

	logic [ENTRY_BITS-1:0] mem [dst_pkg::SLOTS];
	logic [ENTRY_BITS-1:0] mem_rd_q;
	logic [dst_pkg::SLOT_BITS-1:0] rd_addr_q;
	logic [dst_pkg::SLOT_BITS-1:0] rd_addr;
	logic rd_en;
	logic mem_we;
	logic [dst_pkg::SLOT_BITS-1:0] mem_wa;

	logic [dst_pkg::SLOT_BITS-1:0] cursor_q;
	logic pend_valid_q;
	logic [dst_pkg::SLOT_BITS-1:0] pend_slot_q;
	logic [dst_pkg::HANDLE_BITS-1:0] pend_handle_q;
	logic [2:0] pend_kind_q;

	logic out_valid_q;
	dst_pkg::out_item_t out_q;
	logic out_last_q;

	logic init_hit;
	logic [dst_pkg::HANDLE_BITS-1:0] e_handle;
	logic [2:0] e_kind;
	logic [dst_pkg::SLOT_BITS-1:0] idx_lo;
	logic in_range;
	logic free_found;
	logic [dst_pkg::SLOT_BITS-1:0] free_idx;
	dst_pkg::out_item_t res;
	logic out_free;
	logic match;

	assign in_word = dst_pkg::in_item_t'(s_tdata);
	assign idx_lo = idx_q[dst_pkg::SLOT_BITS-1:0];
	assign in_range = !idx_q[15] && (idx_q[14:0] < 15'(dst_pkg::SLOTS));
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		init_hit = 1'b0;
		for (int i = 0; i < dst_pkg::CONSOLE_SLOTS; i++) begin
			if (rd_addr_q == dst_pkg::SLOT_BITS'(i) && init_q[i]) begin
				init_hit = 1'b1;
			end
		end
	end

	assign e_handle = init_hit ? dst_pkg::HANDLE_BITS'(rd_addr_q)
		: mem_rd_q[dst_pkg::HANDLE_BITS-1:0];
	assign e_kind = init_hit ? dst_pkg::KIND_FILE : mem_rd_q[ENTRY_BITS-1 -: 3];

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = dst_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_found = 1'b1;
				free_idx = dst_pkg::SLOT_BITS'(i);
			end
		end
	end

	assign match = occ_q[cursor_q] && (kind_q == dst_pkg::KIND_ANY || e_kind == kind_q);

	always_comb begin
		res = '0;
		case (cmd_q)
			dst_pkg::CMD_ASSIGN: begin
				if (free_found) begin
					res.slot_out = 6'(free_idx);
				end else begin
					res.status = dst_pkg::ST_NO_SPACE;
				end
			end
			dst_pkg::CMD_RELEASE: begin
				if (!in_range) begin
					res.status = dst_pkg::ST_BAD_DESC;
				end else begin
					res.slot_out = 6'(idx_lo);
					if (!occ_q[idx_lo]) begin
						res.status = dst_pkg::ST_INVALID;
					end
				end
			end
			dst_pkg::CMD_REASSIGN: begin
				if (!in_range) begin
					res.status = dst_pkg::ST_BAD_DESC;
				end else begin
					res.slot_out = 6'(idx_lo);
					if (occ_q[idx_lo]) begin
						res.handle_out = 32'(e_handle);
						res.kind_out = e_kind;
						res.found = 1'b1;
					end
				end
			end
			dst_pkg::CMD_GET: begin
				if (!in_range) begin
					res.status = dst_pkg::ST_BAD_DESC;
				end else begin
					res.slot_out = 6'(idx_lo);
					if (!occ_q[idx_lo]) begin
						res.status = dst_pkg::ST_BAD_DESC;
					end else if (kind_q != dst_pkg::KIND_ANY && e_kind != kind_q) begin
						res.status = dst_pkg::ST_INVALID;
					end else begin
						res.handle_out = 32'(e_handle);
						res.kind_out = e_kind;
						res.found = 1'b1;
					end
				end
			end
			default: begin
				res.status = dst_pkg::ST_INVALID;
			end
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_lo;
		if (ctl.commit) begin
			if (cmd_q == dst_pkg::CMD_ASSIGN && free_found) begin
				mem_we = 1'b1;
				mem_wa = free_idx;
			end else if (cmd_q == dst_pkg::CMD_REASSIGN && in_range) begin
				mem_we = 1'b1;
			end
		end
	end

	assign rd_en = ctl.load || ctl.scan_rd;
	assign rd_addr = ctl.load ? in_word.slot_index[dst_pkg::SLOT_BITS-1:0] : cursor_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= {kind_q, hnd_q};
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= in_word.command;
			idx_q <= in_word.slot_index;
			hnd_q <= dst_pkg::HANDLE_BITS'(in_word.handle_in);
			kind_q <= in_word.kind_in;
		end
		if (ctl.scan_step && match) begin
			pend_slot_q <= cursor_q;
			pend_handle_q <= e_handle;
			pend_kind_q <= e_kind;
		end
		if (ctl.commit) begin
			out_q <= res;
			out_last_q <= 1'b1;
		end else if (ctl.scan_step && match && pend_valid_q) begin
			out_q <= '{pad: '0, found: 1'b1, kind_out: pend_kind_q,
				handle_out: 32'(pend_handle_q), slot_out: 6'(pend_slot_q),
				status: dst_pkg::ST_OK};
			out_last_q <= 1'b0;
		end else if (ctl.scan_done) begin
			if (pend_valid_q) begin
				out_q <= '{pad: '0, found: 1'b1, kind_out: pend_kind_q,
					handle_out: 32'(pend_handle_q), slot_out: 6'(pend_slot_q),
					status: dst_pkg::ST_OK};
			end else begin
				out_q <= '0;
			end
			out_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= {{(dst_pkg::SLOTS - dst_pkg::CONSOLE_SLOTS){1'b0}},
				{dst_pkg::CONSOLE_SLOTS{1'b1}}};
			init_q <= '1;
			cursor_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				cursor_q <= '0;
				pend_valid_q <= 1'b0;
			end
			if (ctl.scan_step) begin
				cursor_q <= cursor_q + 1'b1;
				if (match) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (ctl.scan_done) begin
				pend_valid_q <= 1'b0;
			end
			if (ctl.commit) begin
				if (cmd_q == dst_pkg::CMD_ASSIGN && free_found) begin
					occ_q[free_idx] <= 1'b1;
				end else if (cmd_q == dst_pkg::CMD_RELEASE && in_range) begin
					occ_q[idx_lo] <= 1'b0;
				end else if (cmd_q == dst_pkg::CMD_REASSIGN && in_range) begin
					occ_q[idx_lo] <= 1'b1;
				end
			end
			if (mem_we) begin
				for (int i = 0; i < dst_pkg::CONSOLE_SLOTS; i++) begin
					if (mem_wa == dst_pkg::SLOT_BITS'(i)) begin
						init_q[i] <= 1'b0;
					end
				end
			end
			if (ctl.commit || ctl.scan_done || (ctl.scan_step && match && pend_valid_q)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.in_list = (in_word.command == dst_pkg::CMD_LIST);
	assign stat.out_free = out_free;
	assign stat.scan_match = match;
	assign stat.pend_valid = pend_valid_q;
	assign stat.cursor_last = (cursor_q == dst_pkg::SLOT_BITS'(dst_pkg::SLOTS - 1));

	assign m_tvalid = out_valid_q;
	assign m_tdata = 48'(out_q);
	assign m_tlast = out_last_q;

endmodule

FILE: src/dst_checker.sv
module dst_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [47:0] m_tdata,
	input logic m_tlast
);

	// A result that is held back keeps its content until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// An item is worked on alone, so the input closes after each transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input open while an item is in progress");

	// A full table ends the item with no entry.
	a_no_space: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == dst_pkg::ST_NO_SPACE |-> m_tlast && !m_tdata[43])
		else $error("no_space result malformed");

	// A found entry always comes with a good status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[43] |-> m_tdata[1:0] == dst_pkg::ST_OK)
		else $error("found entry with an error status");

endmodule

bind descriptor_slot_table dst_checker u_dst_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);
